// ===== rtl/coalescing_extent_free_list_macros.svh =====
// assertion macros used by the datapath rtl file
// each expects clk and rst_n in the scope of its use
`ifndef COALESCING_EXTENT_FREE_LIST_MACROS_SVH
`define COALESCING_EXTENT_FREE_LIST_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define CEFL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define CEFL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define CEFL_ASSERT_NOW(lbl, ante, cons)
`define CEFL_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/cefl_pkg.sv =====
`timescale 1ns / 1ps

package cefl_pkg;

  localparam int MAX_EXTENTS = 64;
  localparam int IDX_W       = $clog2(MAX_EXTENTS);
  localparam int CNT_W       = $clog2(MAX_EXTENTS + 1);
  localparam int PTR_W       = CNT_W + 2;
  localparam int VAL_W       = 63;
  localparam int KIND_W      = 2;
  localparam int IN_IDX_W    = 6;
  localparam int OUT_IDX_W   = 6;
  localparam int OUT_CNT_W   = 7;
  localparam int IN_DATA_W   = 136;
  localparam int OUT_DATA_W  = 16;

  localparam logic [KIND_W-1:0] KIND_ADD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TAKE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FIND = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_ADD_TEST, S_ADD_CMP, S_INS_CHK, S_BS_TEST, S_BS_CMP,
    S_SH_TEST, S_SH_WR, S_TAKE_CMP, S_DR_TEST, S_DR_WR, S_FD_TEST, S_FD_CMP,
    S_CO_A_TEST, S_CO_A_LD, S_CO_B_TEST, S_CO_B_CMP, S_DONE
  } ctl_state_t;

  typedef enum logic [4:0] {
    DP_NOP, DP_LOAD, DP_RD_K, DP_RD_KM1, DP_RD_KP1, DP_RD_IDX, DP_RD_MID, DP_RD_A,
    DP_K_CLR, DP_K_INC, DP_K_CNT, DP_MERGE_ADD, DP_BS_INIT, DP_BS_LO, DP_BS_HI,
    DP_SH_WR, DP_INS_WR, DP_TAKE_WR, DP_DROP_INIT, DP_DR_WR, DP_CNT_DEC,
    DP_FD_STEP, DP_A_LD, DP_A_INC, DP_CO_HEAD, DP_CO_TAIL, DP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic ovf;
    logic idx_ge_cnt;
    logic k_ge_cnt;
    logic kp1_lt_cnt;
    logic k_gt_lo;
    logic full;
    logic lo_gt_hi;
    logic s_gt_mid;
    logic s_lt_mid;
    logic add_tail;
    logic add_head;
    logic take_lt;
    logic take_eq;
    logic co_head;
    logic co_tail;
    logic a_lt_cnt;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/cefl_ctrl.sv =====
`timescale 1ns / 1ps

module cefl_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  cefl_pkg::dp_status_t st,
  output cefl_pkg::dp_cmd_t    cmd
);

  cefl_pkg::ctl_state_t state_r, state_nxt;
  logic ret_coal_r, ret_coal_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= cefl_pkg::S_IDLE;
      ret_coal_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ret_coal_r <= ret_coal_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    ret_coal_nxt = ret_coal_r;
    cmd.op       = cefl_pkg::DP_NOP;
    in_tready    = 1'b0;
    case (state_r)
      cefl_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op    = cefl_pkg::DP_LOAD;
          state_nxt = cefl_pkg::S_DISPATCH;
        end
      end
      cefl_pkg::S_DISPATCH: begin
        case (st.kind)
          cefl_pkg::KIND_ADD: begin
            if (st.ovf) state_nxt = cefl_pkg::S_DONE;
            else begin
              cmd.op    = cefl_pkg::DP_K_CLR;
              state_nxt = cefl_pkg::S_ADD_TEST;
            end
          end
          cefl_pkg::KIND_TAKE: begin
            if (st.idx_ge_cnt) state_nxt = cefl_pkg::S_DONE;
            else begin
              cmd.op    = cefl_pkg::DP_RD_IDX;
              state_nxt = cefl_pkg::S_TAKE_CMP;
            end
          end
          cefl_pkg::KIND_FIND: begin
            cmd.op    = cefl_pkg::DP_K_CLR;
            state_nxt = cefl_pkg::S_FD_TEST;
          end
          default: state_nxt = cefl_pkg::S_DONE;
        endcase
      end
      cefl_pkg::S_ADD_TEST: begin
        if (st.k_ge_cnt) state_nxt = cefl_pkg::S_INS_CHK;
        else begin
          cmd.op    = cefl_pkg::DP_RD_K;
          state_nxt = cefl_pkg::S_ADD_CMP;
        end
      end
      cefl_pkg::S_ADD_CMP: begin
        if (st.add_tail || st.add_head) begin
          cmd.op    = cefl_pkg::DP_MERGE_ADD;
          state_nxt = cefl_pkg::S_CO_A_TEST;
        end else begin
          cmd.op    = cefl_pkg::DP_K_INC;
          state_nxt = cefl_pkg::S_ADD_TEST;
        end
      end
      cefl_pkg::S_INS_CHK: begin
        if (st.full) state_nxt = cefl_pkg::S_DONE;
        else begin
          cmd.op    = cefl_pkg::DP_BS_INIT;
          state_nxt = cefl_pkg::S_BS_TEST;
        end
      end
      cefl_pkg::S_BS_TEST: begin
        if (st.lo_gt_hi) begin
          cmd.op    = cefl_pkg::DP_K_CNT;
          state_nxt = cefl_pkg::S_SH_TEST;
        end else begin
          cmd.op    = cefl_pkg::DP_RD_MID;
          state_nxt = cefl_pkg::S_BS_CMP;
        end
      end
      cefl_pkg::S_BS_CMP: begin
        if (st.s_gt_mid) begin
          cmd.op    = cefl_pkg::DP_BS_LO;
          state_nxt = cefl_pkg::S_BS_TEST;
        end else if (st.s_lt_mid) begin
          cmd.op    = cefl_pkg::DP_BS_HI;
          state_nxt = cefl_pkg::S_BS_TEST;
        end else begin
          state_nxt = cefl_pkg::S_DONE;
        end
      end
      cefl_pkg::S_SH_TEST: begin
        if (st.k_gt_lo) begin
          cmd.op    = cefl_pkg::DP_RD_KM1;
          state_nxt = cefl_pkg::S_SH_WR;
        end else begin
          cmd.op    = cefl_pkg::DP_INS_WR;
          state_nxt = cefl_pkg::S_DONE;
        end
      end
      cefl_pkg::S_SH_WR: begin
        cmd.op    = cefl_pkg::DP_SH_WR;
        state_nxt = cefl_pkg::S_SH_TEST;
      end
      cefl_pkg::S_TAKE_CMP: begin
        if (st.take_lt) state_nxt = cefl_pkg::S_DONE;
        else if (st.take_eq) begin
          cmd.op       = cefl_pkg::DP_DROP_INIT;
          ret_coal_nxt = 1'b0;
          state_nxt    = cefl_pkg::S_DR_TEST;
        end else begin
          cmd.op    = cefl_pkg::DP_TAKE_WR;
          state_nxt = cefl_pkg::S_DONE;
        end
      end
      cefl_pkg::S_DR_TEST: begin
        if (st.kp1_lt_cnt) begin
          cmd.op    = cefl_pkg::DP_RD_KP1;
          state_nxt = cefl_pkg::S_DR_WR;
        end else begin
          cmd.op    = cefl_pkg::DP_CNT_DEC;
          state_nxt = ret_coal_r ? cefl_pkg::S_CO_A_TEST : cefl_pkg::S_DONE;
        end
      end
      cefl_pkg::S_DR_WR: begin
        cmd.op    = cefl_pkg::DP_DR_WR;
        state_nxt = cefl_pkg::S_DR_TEST;
      end
      cefl_pkg::S_FD_TEST: begin
        if (st.k_ge_cnt) state_nxt = cefl_pkg::S_DONE;
        else begin
          cmd.op    = cefl_pkg::DP_RD_K;
          state_nxt = cefl_pkg::S_FD_CMP;
        end
      end
      cefl_pkg::S_FD_CMP: begin
        cmd.op    = cefl_pkg::DP_FD_STEP;
        state_nxt = cefl_pkg::S_FD_TEST;
      end
      cefl_pkg::S_CO_A_TEST: begin
        if (st.a_lt_cnt) begin
          cmd.op    = cefl_pkg::DP_RD_A;
          state_nxt = cefl_pkg::S_CO_A_LD;
        end else begin
          state_nxt = cefl_pkg::S_DONE;
        end
      end
      cefl_pkg::S_CO_A_LD: begin
        cmd.op    = cefl_pkg::DP_A_LD;
        state_nxt = cefl_pkg::S_CO_B_TEST;
      end
      cefl_pkg::S_CO_B_TEST: begin
        if (!st.k_ge_cnt) begin
          cmd.op    = cefl_pkg::DP_RD_K;
          state_nxt = cefl_pkg::S_CO_B_CMP;
        end else begin
          cmd.op    = cefl_pkg::DP_A_INC;
          state_nxt = cefl_pkg::S_CO_A_TEST;
        end
      end
      cefl_pkg::S_CO_B_CMP: begin
        if (st.co_head) begin
          cmd.op       = cefl_pkg::DP_CO_HEAD;
          ret_coal_nxt = 1'b1;
          state_nxt    = cefl_pkg::S_DR_TEST;
        end else if (st.co_tail) begin
          cmd.op       = cefl_pkg::DP_CO_TAIL;
          ret_coal_nxt = 1'b1;
          state_nxt    = cefl_pkg::S_DR_TEST;
        end else begin
          cmd.op    = cefl_pkg::DP_K_INC;
          state_nxt = cefl_pkg::S_CO_B_TEST;
        end
      end
      cefl_pkg::S_DONE: begin
        if (st.out_free) begin
          cmd.op    = cefl_pkg::DP_EMIT;
          state_nxt = cefl_pkg::S_IDLE;
        end
      end
      default: state_nxt = cefl_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== rtl/cefl_dp.sv =====
`timescale 1ns / 1ps
`include "coalescing_extent_free_list_macros.svh"

module cefl_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  cefl_pkg::dp_cmd_t                   cmd,
  output cefl_pkg::dp_status_t                st,
  input  logic [cefl_pkg::KIND_W-1:0]         in_kind,
  input  logic [cefl_pkg::VAL_W-1:0]          in_start,
  input  logic [cefl_pkg::VAL_W-1:0]          in_len,
  input  logic [cefl_pkg::IN_IDX_W-1:0]       in_idx,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_ok,
  output logic [cefl_pkg::OUT_IDX_W-1:0]      out_found,
  output logic [cefl_pkg::OUT_CNT_W-1:0]      out_cnt
);

  localparam int N = cefl_pkg::MAX_EXTENTS;
  localparam int IW = cefl_pkg::IDX_W;
  localparam int CW = cefl_pkg::CNT_W;
  localparam int PW = cefl_pkg::PTR_W;
  localparam int VW = cefl_pkg::VAL_W;

  logic [VW-1:0] mem_s [N];
  logic [VW-1:0] mem_l [N];

  logic [cefl_pkg::KIND_W-1:0] kind_r;
  logic [VW-1:0] s_r, len_r, send_r, rd_s_r, rd_l_r, a_s_r, a_l_r, best_r;
  logic [cefl_pkg::IN_IDX_W-1:0] idx_r;
  logic ovf_r, ok_r;
  logic [IW-1:0] found_r, mid_r;
  logic [CW-1:0] count_r, k_r, a_r;
  logic signed [PW-1:0] lo_r, hi_r;
  logic out_valid_r, out_ok_r;
  logic [cefl_pkg::OUT_IDX_W-1:0] out_found_r;
  logic [cefl_pkg::OUT_CNT_W-1:0] out_cnt_r;

  logic [VW:0] in_sum;
  logic [VW-1:0] rd_end, a_end;
  logic signed [PW-1:0] mid_sum;
  logic [IW-1:0] rd_addr, wr_addr;
  logic rd_en, wr_en;
  logic [VW-1:0] wr_s, wr_l;
  logic fd_hit;

  assign in_sum  = {1'b0, in_start} + {1'b0, in_len};
  assign rd_end  = rd_s_r + rd_l_r;
  assign a_end   = a_s_r + a_l_r;
  assign mid_sum = (lo_r + hi_r) >>> 1;
  assign fd_hit  = (rd_l_r >= len_r) && (!ok_r || (rd_l_r < best_r));

  // read port select
  always_comb begin
    rd_en   = 1'b1;
    rd_addr = k_r[IW-1:0];
    case (cmd.op)
      cefl_pkg::DP_RD_K:   rd_addr = k_r[IW-1:0];
      cefl_pkg::DP_RD_KM1: rd_addr = IW'(k_r - CW'(1));
      cefl_pkg::DP_RD_KP1: rd_addr = IW'(k_r + CW'(1));
      cefl_pkg::DP_RD_IDX: rd_addr = IW'(idx_r);
      cefl_pkg::DP_RD_MID: rd_addr = mid_sum[IW-1:0];
      cefl_pkg::DP_RD_A:   rd_addr = a_r[IW-1:0];
      default:             rd_en   = 1'b0;
    endcase
  end

  // write port select
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = k_r[IW-1:0];
    wr_s    = rd_s_r;
    wr_l    = rd_l_r;
    case (cmd.op)
      cefl_pkg::DP_MERGE_ADD: begin
        wr_s = st.add_tail ? rd_s_r : s_r;
        wr_l = rd_l_r + len_r;
      end
      cefl_pkg::DP_SH_WR, cefl_pkg::DP_DR_WR: begin
        wr_addr = k_r[IW-1:0];
      end
      cefl_pkg::DP_INS_WR: begin
        wr_addr = lo_r[IW-1:0];
        wr_s    = s_r;
        wr_l    = len_r;
      end
      cefl_pkg::DP_TAKE_WR: begin
        wr_addr = IW'(idx_r);
        wr_s    = rd_s_r + len_r;
        wr_l    = rd_l_r - len_r;
      end
      cefl_pkg::DP_CO_HEAD: begin
        wr_addr = a_r[IW-1:0];
        wr_s    = rd_s_r;
        wr_l    = a_l_r + rd_l_r;
      end
      cefl_pkg::DP_CO_TAIL: begin
        wr_addr = a_r[IW-1:0];
        wr_s    = a_s_r;
        wr_l    = a_l_r + rd_l_r;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_s[wr_addr] <= wr_s;
      mem_l[wr_addr] <= wr_l;
    end
    if (rd_en) begin
      rd_s_r <= mem_s[rd_addr];
      rd_l_r <= mem_l[rd_addr];
    end
  end

  // payload and work registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      cefl_pkg::DP_LOAD: begin
        kind_r <= in_kind;
        s_r    <= in_start;
        len_r  <= in_len;
        send_r <= in_sum[VW-1:0];
        ovf_r  <= in_sum[VW];
        idx_r  <= in_idx;
        best_r <= '0;
      end
      cefl_pkg::DP_RD_MID: mid_r <= mid_sum[IW-1:0];
      cefl_pkg::DP_BS_INIT: begin
        lo_r <= '0;
        hi_r <= PW'(count_r) - PW'(1);
      end
      cefl_pkg::DP_BS_LO: lo_r <= PW'(mid_r) + PW'(1);
      cefl_pkg::DP_BS_HI: hi_r <= PW'(mid_r) - PW'(1);
      cefl_pkg::DP_FD_STEP: begin
        if (fd_hit) best_r <= rd_l_r;
      end
      cefl_pkg::DP_A_LD: begin
        a_s_r <= rd_s_r;
        a_l_r <= rd_l_r;
      end
      cefl_pkg::DP_CO_HEAD: begin
        a_s_r <= rd_s_r;
        a_l_r <= a_l_r + rd_l_r;
      end
      cefl_pkg::DP_CO_TAIL: a_l_r <= a_l_r + rd_l_r;
      default: ;
    endcase
  end

  // counters and flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      k_r         <= '0;
      a_r         <= '0;
      ok_r        <= 1'b0;
      found_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a new result may replace one leaving in the same cycle
      out_valid_r <= (cmd.op == cefl_pkg::DP_EMIT) || (out_valid_r && !out_ready);
      case (cmd.op)
        cefl_pkg::DP_LOAD: begin
          ok_r    <= 1'b0;
          found_r <= '0;
        end
        cefl_pkg::DP_K_CLR: k_r <= '0;
        cefl_pkg::DP_K_INC: k_r <= k_r + CW'(1);
        cefl_pkg::DP_K_CNT: k_r <= count_r;
        cefl_pkg::DP_MERGE_ADD: begin
          ok_r <= 1'b1;
          a_r  <= '0;
        end
        cefl_pkg::DP_SH_WR: k_r <= k_r - CW'(1);
        cefl_pkg::DP_INS_WR: begin
          ok_r    <= 1'b1;
          count_r <= count_r + CW'(1);
        end
        cefl_pkg::DP_TAKE_WR: ok_r <= 1'b1;
        cefl_pkg::DP_DROP_INIT: begin
          ok_r <= 1'b1;
          k_r  <= CW'(idx_r);
        end
        cefl_pkg::DP_DR_WR: k_r <= k_r + CW'(1);
        cefl_pkg::DP_CNT_DEC: begin
          count_r <= count_r - CW'(1);
          a_r     <= '0;
        end
        cefl_pkg::DP_FD_STEP: begin
          if (fd_hit) begin
            ok_r    <= 1'b1;
            found_r <= k_r[IW-1:0];
          end
          k_r <= k_r + CW'(1);
        end
        cefl_pkg::DP_A_LD: k_r <= a_r + CW'(1);
        cefl_pkg::DP_A_INC: a_r <= a_r + CW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == cefl_pkg::DP_EMIT) begin
      out_ok_r    <= ok_r;
      out_found_r <= cefl_pkg::OUT_IDX_W'(found_r);
      out_cnt_r   <= cefl_pkg::OUT_CNT_W'(count_r);
    end
  end

  always_comb begin
    st.kind       = kind_r;
    st.ovf        = ovf_r;
    st.idx_ge_cnt = (CW'(idx_r) >= count_r);
    st.k_ge_cnt   = (k_r >= count_r);
    st.kp1_lt_cnt = (({1'b0, k_r} + (CW+1)'(1)) < {1'b0, count_r});
    st.k_gt_lo    = (PW'(k_r) > lo_r);
    st.full       = (count_r >= CW'(N));
    st.lo_gt_hi   = (lo_r > hi_r);
    st.s_gt_mid   = (s_r > rd_s_r);
    st.s_lt_mid   = (s_r < rd_s_r);
    st.add_tail   = (rd_end == s_r);
    st.add_head   = (rd_s_r == send_r);
    st.take_lt    = (rd_l_r < len_r);
    st.take_eq    = (rd_l_r == len_r);
    st.co_head    = (rd_end == a_s_r);
    st.co_tail    = (rd_s_r == a_end);
    st.a_lt_cnt   = (a_r < count_r);
    st.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_ok    = out_ok_r;
  assign out_found = out_found_r;
  assign out_cnt   = out_cnt_r;

  `CEFL_ASSERT_NOW(a_cnt_range, 1'b1, count_r <= CW'(N))
  `CEFL_ASSERT_NOW(a_ins_room, cmd.op == cefl_pkg::DP_INS_WR, count_r < CW'(N))
  `CEFL_ASSERT_NOW(a_dec_nonzero, cmd.op == cefl_pkg::DP_CNT_DEC, count_r != '0)
  `CEFL_ASSERT_NEXT(a_emit_valid, cmd.op == cefl_pkg::DP_EMIT, out_valid_r)

endmodule

// ===== rtl/coalescing_extent_free_list.sv =====
`timescale 1ns / 1ps
// channel   | dir | tdata (low bit up)                          | tuser
// in_       | in  | start_req[62:0] length[125:63] index[131:126]| kind[1:0]
// out_      | out | ok[0] found_index[6:1] entries_in_use[13:7]  | -
//
// one item at a time, set by the extent memory, read or written once per step: a find or a
// failed check scans the entries in turn, an insert adds a binary search and a shift of each
// entry after the insert point, a merge runs the pairwise coalesce pass (restarted per join)
// reset (rst_n low, synchronous) empties the table; memory contents are not cleared
// in_tready is high only while idle; a new item is taken while a result still waits
// a stalled result holds the block in its last step until the output transfer

module coalescing_extent_free_list (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // start_req[62:0], length[125:63], index[131:126], zero fill
  input  logic [cefl_pkg::IN_DATA_W-1:0]    in_tdata,
  // kind[1:0]
  input  logic [cefl_pkg::KIND_W-1:0]       in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // ok[0], found_index[6:1], entries_in_use[13:7], zero fill
  output logic [cefl_pkg::OUT_DATA_W-1:0]   out_tdata
);

  cefl_pkg::dp_cmd_t    cmd;
  cefl_pkg::dp_status_t st;
  logic                                ok;
  logic [cefl_pkg::OUT_IDX_W-1:0]      found;
  logic [cefl_pkg::OUT_CNT_W-1:0]      cnt;

  // sequencer: one state per memory step
  cefl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  // extent memory, counters, compares and result register
  cefl_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .in_kind   (in_tuser),
    .in_start  (in_tdata[62:0]),
    .in_len    (in_tdata[125:63]),
    .in_idx    (in_tdata[131:126]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_ok    (ok),
    .out_found (found),
    .out_cnt   (cnt)
  );

  // pack the result fields, low bits first
  assign out_tdata = {2'b00, cnt, found, ok};

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

// free-extent table with merge, coalesce, take and best fit: self-checking bench
// a scoreboard mirrors the extent table and predicts each result at input transfer

class extent_scoreboard;
  localparam int DEPTH = cefl_pkg::MAX_EXTENTS;
  localparam logic [63:0] OFFSET_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  logic [62:0] ext_start [DEPTH];
  logic [62:0] ext_len [DEPTH];
  int          used;
  logic [13:0] awaited [$];
  int          errors;

  function void clear();
    used = 0;
    errors = 0;
    awaited.delete();
  endfunction

  function void drop_at(int pos);
    for (int k = pos; k + 1 < used; k++) begin
      ext_start[k] = ext_start[k+1];
      ext_len[k]   = ext_len[k+1];
    end
    used--;
  endfunction

  // join touching pairs, restarting after every join
  function void join_touching();
    bit again;
    again = 1;
    while (again) begin
      again = 0;
      for (int a = 0; a < used && !again; a++) begin
        for (int b = a + 1; b < used && !again; b++) begin
          if (ext_start[b] + ext_len[b] == ext_start[a]) begin
            ext_start[a] = ext_start[b];
            ext_len[a]   = ext_len[a] + ext_len[b];
            drop_at(b);
            again = 1;
          end else if (ext_start[b] == ext_start[a] + ext_len[a]) begin
            ext_len[a] = ext_len[a] + ext_len[b];
            drop_at(b);
            again = 1;
          end
        end
      end
    end
  endfunction

  function bit add_extent(logic [62:0] s, logic [62:0] len);
    int lo;
    int hi;
    int mid;
    if ({1'b0, s} > OFFSET_MAX - {1'b0, len}) return 0;
    for (int k = 0; k < used; k++) begin
      if (ext_start[k] + ext_len[k] == s) begin
        ext_len[k] = ext_len[k] + len;
        join_touching();
        return 1;
      end
      if (ext_start[k] == s + len) begin
        ext_start[k] = s;
        ext_len[k]   = ext_len[k] + len;
        join_touching();
        return 1;
      end
    end
    if (used >= DEPTH) return 0;
    lo = 0;
    hi = used - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (s > ext_start[mid]) lo = mid + 1;
      else if (s < ext_start[mid]) hi = mid - 1;
      else return 0;
    end
    for (int k = used; k > lo; k--) begin
      ext_start[k] = ext_start[k-1];
      ext_len[k]   = ext_len[k-1];
    end
    ext_start[lo] = s;
    ext_len[lo]   = len;
    used++;
    return 1;
  endfunction

  function bit take_extent(int pos, logic [62:0] len);
    if (pos >= used || ext_len[pos] < len) return 0;
    if (ext_len[pos] == len) drop_at(pos);
    else begin
      ext_start[pos] = ext_start[pos] + len;
      ext_len[pos]   = ext_len[pos] - len;
    end
    return 1;
  endfunction

  // input transfer: update the mirror and queue the expected result
  function void note_item(logic [1:0] kind, logic [62:0] s, logic [62:0] len,
                          logic [5:0] idx);
    bit          ok;
    logic [5:0]  found;
    logic [62:0] best;
    ok = 0;
    found = '0;
    best = '0;
    case (kind)
      cefl_pkg::KIND_ADD:  ok = add_extent(s, len);
      cefl_pkg::KIND_TAKE: ok = take_extent(int'(idx), len);
      cefl_pkg::KIND_FIND: begin
        for (int k = 0; k < used; k++) begin
          if (ext_len[k] >= len && (!ok || ext_len[k] < best)) begin
            ok = 1;
            best = ext_len[k];
            found = k[5:0];
          end
        end
      end
      default: ;
    endcase
    awaited.push_back({7'(used), found, ok});
  endfunction

  function void check_result(logic [15:0] d);
    logic [13:0] want;
    if (awaited.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result %h", d);
      return;
    end
    want = awaited.pop_front();
    if (d[0] !== want[0] || d[6:1] !== want[6:1] || d[13:7] !== want[13:7]) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: ok %0d/%0d found_index %0d/%0d entries_in_use %0d/%0d",
                 want[0], d[0], want[6:1], d[6:1], want[13:7], d[13:7]);
    end
  endfunction
endclass

module tb_top;
  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam logic [62:0] OFS_MAX = 63'h7FFF_FFFF_FFFF_FFFF;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [cefl_pkg::IN_DATA_W-1:0] in_tdata;
  logic [cefl_pkg::KIND_W-1:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [cefl_pkg::OUT_DATA_W-1:0] out_tdata;

  extent_scoreboard sb;
  bit no_idle;
  bit hold_req;
  bit hold_taken;
  int hold_cycles;

  coalescing_extent_free_list dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // one item per call; valid stays high into the next call unless it idles
  task automatic send_item(logic [1:0] kind, logic [62:0] s, logic [62:0] len,
                           logic [5:0] idx);
    @(negedge clk);
    while (!no_idle && $urandom_range(0, 99) < 25) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {4'b0, idx, len, s};
    do @(posedge clk); while (!in_tready);
    sb.note_item(kind, s, len, idx);
  endtask

  // mostly well-formed items on a small offset grid so merges and takes hit
  task automatic random_item();
    int          pick;
    int          pos;
    logic [62:0] len;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      send_item(cefl_pkg::KIND_ADD, 63'($urandom_range(0, 255) * 8),
                63'($urandom_range(1, 4) * 8), 6'($urandom));
    end else if (pick < 70 && sb.used > 0) begin
      pos = $urandom_range(0, sb.used - 1);
      case ($urandom_range(0, 3))
        0, 1:    len = sb.ext_len[pos];
        2:       len = sb.ext_len[pos] >> $urandom_range(1, 4);
        default: len = sb.ext_len[pos] + 63'd1;
      endcase
      send_item(cefl_pkg::KIND_TAKE, 63'($urandom), len, 6'(pos));
    end else if (pick < 88) begin
      send_item(cefl_pkg::KIND_FIND, 63'($urandom),
                63'($urandom_range(0, 80)), 6'($urandom));
    end else begin
      // noise over the full field ranges
      send_item(2'($urandom), 63'({$urandom, $urandom}), 63'({$urandom, $urandom}),
                6'($urandom));
    end
  endtask

  // receiver: random idling plus a counted long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready  <= 1'b0;
      hold_cycles <= 0;
      hold_taken  <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      out_tready  <= 1'b0;
      hold_cycles <= 20_000;
      hold_taken  <= 1'b1;
    end else if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else out_tready <= no_idle || ($urandom_range(0, 99) >= 25);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  initial begin
    #(4 * 100_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int wait_cnt;
    sb = new();
    sb.clear();
    no_idle = 0;
    hold_req = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = cefl_pkg::KIND_ADD;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty-table cases, extremes, merges from both sides
    send_item(cefl_pkg::KIND_FIND, 63'd0, 63'd0, 6'd0);
    send_item(cefl_pkg::KIND_TAKE, 63'd0, 63'd0, 6'd0);
    send_item(KIND_NONE, OFS_MAX, OFS_MAX, 6'd63);
    send_item(cefl_pkg::KIND_ADD, OFS_MAX, 63'd1, 6'd0);
    send_item(cefl_pkg::KIND_ADD, 63'd1, OFS_MAX, 6'd0);
    send_item(cefl_pkg::KIND_ADD, 63'd100, 63'd50, 6'd0);
    send_item(cefl_pkg::KIND_ADD, 63'd100, 63'd10, 6'd0);
    send_item(cefl_pkg::KIND_ADD, 63'd300, 63'd20, 6'd0);
    send_item(cefl_pkg::KIND_ADD, 63'd150, 63'd50, 6'd0);
    send_item(cefl_pkg::KIND_ADD, 63'd200, 63'd100, 6'd0);
    send_item(cefl_pkg::KIND_ADD, 63'd10, 63'd0, 6'd0);
    send_item(cefl_pkg::KIND_ADD, 63'd500, 63'd0, 6'd0);
    send_item(cefl_pkg::KIND_ADD, OFS_MAX - 63'd5, 63'd5, 6'd0);
    send_item(cefl_pkg::KIND_FIND, 63'd0, 63'd5, 6'd0);
    send_item(cefl_pkg::KIND_FIND, 63'd0, OFS_MAX, 6'd0);
    send_item(cefl_pkg::KIND_TAKE, 63'd0, 63'd1000, 6'd0);
    send_item(cefl_pkg::KIND_TAKE, 63'd0, 63'd20, 6'd0);
    send_item(cefl_pkg::KIND_TAKE, 63'd0, 63'd1, 6'd63);
    send_item(cefl_pkg::KIND_TAKE, 63'd0, 63'd0, 6'd1);
    send_item(KIND_NONE, 63'd0, 63'd0, 6'd0);

    // random items, with a no-idle stretch, a long receiver hold-off and a fill burst
    for (int n = 0; n < 1300; n++) begin
      no_idle = (n >= 300 && n < 500);
      if (n == 150) hold_req = 1;
      if (n == 700) begin
        // gapped inserts past the grid fill the table, then a touching and a gapped add while full
        for (int k = 0; k < 70; k++)
          send_item(cefl_pkg::KIND_ADD, 63'(8192 + k * 128),
                    63'($urandom_range(1, 60)), 6'($urandom));
        send_item(cefl_pkg::KIND_ADD, 63'(8192 - 8), 63'd8, 6'd0);
        send_item(cefl_pkg::KIND_ADD, 63'(100000), 63'd8, 6'd0);
      end
      random_item();
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    wait_cnt = 0;
    while (sb.awaited.size() != 0 && wait_cnt < 2_000_000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (200) @(posedge clk);
    if (sb.awaited.size() == 0 && sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
